// File: rtl/core/pss_pkg.sv
// ----------------------------------------------------------------------------
// PLL setting search package
// Shared types, constants and codes for the PLL setting search block.
// ----------------------------------------------------------------------------
package pss_pkg;

	localparam int unsigned WordW = 32;
	localparam int unsigned ModeW = 25;
	localparam int unsigned IdxW  = 3;
	localparam int unsigned PMax  = 30;
	localparam int unsigned DMax  = 64;
	localparam int unsigned MMax  = 1024;

	localparam logic [31:0] FastXtalHz   = 32'd16000000;
	localparam logic [3:0]  CcssSlowXtal = 4'hF;
	localparam logic [3:0]  CcssFastXtal = 4'hB;
	localparam logic [3:0]  CcssDirect   = 4'h7;

	localparam logic [IdxW-1:0] RegInputClock = 3'd0;
	localparam logic [IdxW-1:0] RegTolerance  = 3'd1;
	localparam logic [IdxW-1:0] RegVcoMax     = 3'd2;
	localparam logic [IdxW-1:0] RegVcoMin     = 3'd3;
	localparam logic [IdxW-1:0] RegPllInMin   = 3'd4;
	localparam logic [IdxW-1:0] RegCrystal    = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PCHK,
		ST_PCHK_WAIT,
		ST_FVAL,
		ST_FVAL_WAIT,
		ST_FIN,
		ST_FIN_WAIT,
		ST_MDIV,
		ST_MDIV_WAIT,
		ST_VCO,
		ST_VCO_WAIT,
		ST_EVAL,
		ST_NEXT_D,
		ST_NEXT_P,
		ST_DONE
	} state_t;

	// Operation of the shared serial arithmetic unit.
	typedef enum logic [1:0] {
		OP_DIV,
		OP_MUL
	} op_t;

	typedef struct packed {
		logic start;
		op_t  op;
	} alu_ctl_t;

endpackage

// File: rtl/core/pss_if.sv
// ----------------------------------------------------------------------------
// PLL setting search channels
// Valid/ready channels for the request, the result and configuration.
// ----------------------------------------------------------------------------
interface pss_req_if;
	logic        valid;
	logic        ready;
	logic [31:0] desired_hz;
	modport source (output valid, output desired_hz, input ready);
	modport sink (input valid, input desired_hz, output ready);
endinterface

interface pss_rsp_if;
	logic        valid;
	logic        ready;
	logic [24:0] mode_word;
	logic        found;
	modport source (output valid, output mode_word, output found, input ready);
	modport sink (input valid, input mode_word, input found, output ready);
endinterface

interface pss_cfg_if;
	logic        valid;
	logic        ready;
	logic [2:0]  index;
	logic [31:0] data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

// File: rtl/core/pss_alu.sv
// ----------------------------------------------------------------------------
// PLL setting search serial arithmetic unit
// Bit-serial 64/32 restoring divider and 64x32 shift-add multiplier with a 64-bit product.
// ----------------------------------------------------------------------------
module pss_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  pss_pkg::alu_ctl_t ctl,
	input  logic [63:0]       a,
	input  logic [31:0]       b,
	output logic              busy,
	output logic [63:0]       result
);
	import pss_pkg::*;

	logic [63:0] acc_q;
	logic [32:0] rem_q;
	logic [31:0] b_q;
	logic [63:0] prod_q;
	logic [6:0]  cnt_q;
	op_t         op_q;
	logic        busy_q;
	logic [32:0] rem_sh;
	logic [33:0] rem_sub;
	logic [63:0] prod_add;

	// One quotient bit per cycle; the remainder stays below the divisor.
	always_comb begin
		rem_sh   = {rem_q[31:0], acc_q[63]};
		rem_sub  = {1'b0, rem_sh} - {2'b0, b_q};
		prod_add = {prod_q[62:0], 1'b0} + (acc_q[63] ? {32'b0, b_q} : 64'b0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q  <= 7'd64;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 7'd1;
			if (cnt_q == 7'd1) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			acc_q  <= a;
			b_q    <= b;
			rem_q  <= '0;
			prod_q <= '0;
			op_q   <= ctl.op;
		end else if (busy_q) begin
			if (op_q == OP_DIV) begin
				if (!rem_sub[33]) begin
					rem_q <= rem_sub[32:0];
					acc_q <= {acc_q[62:0], 1'b1};
				end else begin
					rem_q <= rem_sh;
					acc_q <= {acc_q[62:0], 1'b0};
				end
			end else begin
				prod_q <= prod_add;
				acc_q  <= {acc_q[62:0], 1'b0};
			end
		end
	end

	assign busy   = busy_q;
	assign result = (op_q == OP_DIV) ? acc_q : prod_q;

endmodule

// File: rtl/core/pll_setting_search.sv
// ----------------------------------------------------------------------------
// PLL setting search
// Finds the PLL divider, multiplier and post divider closest to a request.
// ----------------------------------------------------------------------------
// For each request word, each trial pair of post divider P and input
// divider D runs passes through a single bit-serial divide/multiply unit;
// a full search covers 16 by 64 pairs, and an early stop on VCO or
// input limits makes it far shorter. The unit handles one request at a
// time; ready drops while a search runs. Configuration words change the
// limits and are to be written only while the block is idle.
module pll_setting_search (
	input logic clk,
	input logic arst_n,
	pss_req_if.sink   req,
	pss_rsp_if.source rsp,
	pss_cfg_if.sink   cfg
);
	import pss_pkg::*;

	logic [31:0] in_clk_q, tol_q, vmax_q, vmin_q, pmin_q;
	logic        xtal_q;

	state_t      state_q, state_d;
	logic [31:0] desired_q;
	logic [4:0]  p_q;
	logic [6:0]  d_q;
	logic [63:0] fval_q;
	logic [31:0] fin_q;
	logic [63:0] m_q;
	logic [63:0] vco_q;
	logic [32:0] best_q;
	logic [24:0] word_q;
	logic        rsp_valid_q;
	logic [24:0] rsp_word_q;

	alu_ctl_t    alu_ctl;
	logic        alu_busy;
	logic [63:0] alu_a, alu_res;
	logic [31:0] alu_b;

	pss_alu u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(alu_ctl), .a(alu_a), .b(alu_b),
		.busy(alu_busy), .result(alu_res)
	);

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_clk_q <= 32'd20000000;
			tol_q    <= 32'd500000;
			vmax_q   <= 32'd350000000;
			vmin_q   <= 32'd100000000;
			pmin_q   <= 32'd500000;
			xtal_q   <= 1'b1;
		end else if (cfg.valid) begin
			case (cfg.index)
				RegInputClock: in_clk_q <= cfg.data;
				RegTolerance:  tol_q    <= cfg.data;
				RegVcoMax:     vmax_q   <= cfg.data;
				RegVcoMin:     vmin_q   <= cfg.data;
				RegPllInMin:   pmin_q   <= cfg.data;
				RegCrystal:    xtal_q   <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// Error terms of a trial, against the base and the raised multiplier.
	logic [63:0] err0, err1, vco1, err_pick, m_pick;
	logic        try_up, pick_up, better;
	logic [3:0]  pcode;
	logic [63:0] m_adj;
	always_comb begin
		vco1   = vco_q + {32'b0, fin_q};
		err0   = (fval_q > vco_q) ? fval_q - vco_q : vco_q - fval_q;
		err1   = (fval_q > vco1) ? fval_q - vco1 : vco1 - fval_q;
		try_up = (m_q < 64'(MMax)) && (vco1 < {32'b0, vmax_q});
		pick_up  = try_up && (err0 > err1);
		err_pick = pick_up ? err1 : err0;
		m_pick   = pick_up ? m_q + 64'd1 : m_q;
		better   = (err_pick < {31'b0, best_q}) && (err_pick <= {32'b0, tol_q});
		pcode    = 4'({1'b0, p_q[4:1]} - 5'd1);
		m_adj    = (m_q == 64'd0) ? 64'd1 : m_q;
	end

	logic req_fire, rsp_fire;
	assign req_fire = req.valid && req.ready;
	assign rsp_fire = rsp_valid_q && rsp.ready;
	assign req.ready = (state_q == ST_IDLE) && !rsp_valid_q;

	always_comb begin
		state_d     = state_q;
		alu_ctl     = '{start: 1'b0, op: OP_DIV};
		alu_a       = '0;
		alu_b       = '0;
		case (state_q)
			ST_IDLE: if (req_fire) state_d = ST_PCHK;
			ST_PCHK: begin
				if (p_q == 5'd0) begin
					state_d = ST_FVAL;
				end else begin
					alu_ctl = '{start: 1'b1, op: OP_DIV};
					alu_a   = {32'b0, vmax_q};
					alu_b   = {27'b0, p_q};
					state_d = ST_PCHK_WAIT;
				end
			end
			ST_PCHK_WAIT: if (!alu_busy) begin
				state_d = ({32'b0, desired_q} > alu_res) ? ST_DONE : ST_FVAL;
			end
			ST_FVAL: begin
				if (p_q == 5'd0) begin
					state_d = (desired_q > vmax_q) ? ST_DONE : ST_FIN;
				end else begin
					alu_ctl = '{start: 1'b1, op: OP_MUL};
					alu_a   = {32'b0, desired_q};
					alu_b   = {27'b0, p_q};
					state_d = ST_FVAL_WAIT;
				end
			end
			ST_FVAL_WAIT: if (!alu_busy) state_d = ST_FIN;
			ST_FIN: begin
				alu_ctl = '{start: 1'b1, op: OP_DIV};
				alu_a   = {32'b0, in_clk_q};
				alu_b   = {25'b0, d_q};
				state_d = ST_FIN_WAIT;
			end
			ST_FIN_WAIT: if (!alu_busy) begin
				state_d = (alu_res == 64'd0 || alu_res < {32'b0, pmin_q})
					? ST_NEXT_P : ST_MDIV;
			end
			ST_MDIV: begin
				alu_ctl = '{start: 1'b1, op: OP_DIV};
				alu_a   = fval_q;
				alu_b   = fin_q;
				state_d = ST_MDIV_WAIT;
			end
			ST_MDIV_WAIT: if (!alu_busy) begin
				state_d = (alu_res > 64'(MMax)) ? ST_NEXT_P : ST_VCO;
			end
			ST_VCO: begin
				alu_ctl = '{start: 1'b1, op: OP_MUL};
				alu_a   = m_adj;
				alu_b   = fin_q;
				state_d = ST_VCO_WAIT;
			end
			ST_VCO_WAIT: if (!alu_busy) begin
				state_d = (alu_res < {32'b0, vmin_q} || alu_res > {32'b0, vmax_q})
					? ST_NEXT_P : ST_EVAL;
			end
			ST_EVAL: begin
				if (better && err_pick == 64'd0) state_d = ST_DONE;
				else state_d = ST_NEXT_D;
			end
			ST_NEXT_D: state_d = (d_q == 7'(DMax)) ? ST_NEXT_P : ST_FIN;
			ST_NEXT_P: state_d = (p_q == 5'(PMax)) ? ST_DONE : ST_PCHK;
			ST_DONE: state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_DONE) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_fire) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: if (req_fire) begin
				desired_q <= req.desired_hz;
				p_q       <= '0;
				best_q    <= 33'h0FFFFFFFF;
				word_q    <= '0;
			end
			ST_FVAL: begin
				fval_q <= {32'b0, desired_q};
				d_q    <= 7'd1;
			end
			ST_FVAL_WAIT: if (!alu_busy) begin
				fval_q <= alu_res;
				d_q    <= 7'd1;
			end
			ST_FIN_WAIT: if (!alu_busy) fin_q <= alu_res[31:0];
			ST_MDIV_WAIT: if (!alu_busy) m_q <= alu_res;
			ST_VCO_WAIT: if (!alu_busy) begin
				vco_q <= alu_res;
				m_q   <= m_adj;
			end
			ST_EVAL: if (better) begin
				best_q <= err_pick[32:0];
				word_q <= {1'b0, 6'(d_q - 7'd1), 10'(m_pick - 64'd1), pcode, 4'b0};
			end
			ST_NEXT_D: d_q <= d_q + 7'd1;
			ST_NEXT_P: p_q <= p_q + 5'd2;
			ST_DONE: begin
				if (word_q != '0) begin
					rsp_word_q <= {1'b1, word_q[23:4],
						xtal_q ? ((in_clk_q < FastXtalHz) ? CcssSlowXtal : CcssFastXtal)
						       : CcssDirect};
				end else begin
					rsp_word_q <= '0;
				end
			end
			default: ;
		endcase
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.mode_word = rsp_word_q;
	assign rsp.found     = rsp_word_q != '0;

	// A result word is not offered while a search is still running.
	a_no_rsp_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (state_q == ST_IDLE || state_q == ST_DONE || state_q == ST_PCHK))
		else $error("result valid during search");
	// A finished search always raises the result valid.
	a_done_valid: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |=> rsp_valid_q)
		else $error("done without result");
	// The best error never exceeds the tolerance once a word was found.
	a_best_tol: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EVAL && better) |=> best_q <= {1'b0, tol_q})
		else $error("best error beyond tolerance");

endmodule

// File: dv/tb_pll_setting_search.sv
// ----------------------------------------------------------------------------
// PLL setting search testbench
// Drives request words through the search block under several register
// settings, predicts each mode word in place and checks every response word.
// ----------------------------------------------------------------------------
module tb_pll_setting_search;
	import pss_pkg::*;

	// The limit covers every word running the full search several times over.
	localparam int unsigned LimitCycles = 100000000;
	localparam int unsigned DrainCycles = 300;

	typedef struct packed {
		logic [24:0] mode_word;
		logic        found;
	} mode_rsp_t;

	logic clk;
	logic arst_n;

	pss_req_if req ();
	pss_rsp_if rsp ();
	pss_cfg_if cfg ();

	pll_setting_search i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req.sink),
		.rsp    (rsp.source),
		.cfg    (cfg.sink)
	);

	// Local copy of the limit registers, updated as each config word lands.
	logic [31:0] clk_in_hz;
	logic [31:0] tol_hz;
	logic [31:0] vco_hi_hz;
	logic [31:0] vco_lo_hz;
	logic [31:0] pll_in_lo_hz;
	logic        use_xtal;

	logic [31:0] desired_q[$];
	mode_rsp_t   mode_q[$];
	logic [34:0] cfg_q[$];

	int unsigned cycles;
	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned words_checked;
	int unsigned words_found;
	bit          quiet_stretch;
	bit          hold_req;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bit-accurate search for the mode word; 64-bit sums never wrap.
	function automatic mode_rsp_t search_mode(input logic [31:0] want);
		logic [63:0] best;
		logic [31:0] mword;
		logic [63:0] fval;
		logic [63:0] fin;
		logic [63:0] mult;
		logic [63:0] vco;
		logic [63:0] err;
		logic [63:0] alt;
		logic [3:0]  pcode;
		mode_rsp_t   r;
		best  = 64'hFFFF_FFFF;
		mword = '0;
		for (int p = 0; p <= PMax; p += 2) begin
			if (p != 0) begin
				if (want > vco_hi_hz / p)
					break;
				fval = 64'(want) * p;
			end else begin
				fval = 64'(want);
				if (fval > 64'(vco_hi_hz))
					break;
			end
			for (int d = 1; d <= DMax; d++) begin
				fin = 64'(clk_in_hz / d);
				if (fin == 0 || fin < 64'(pll_in_lo_hz))
					break;
				mult = fval / fin;
				if (mult > MMax)
					break;
				if (mult == 0)
					mult = 1;
				vco = fin * mult;
				if (vco < 64'(vco_lo_hz) || vco > 64'(vco_hi_hz))
					break;
				err = (fval > vco) ? fval - vco : vco - fval;
				// The second chance at M+1 only counts when it stays under the VCO limit.
				if (mult < MMax && vco + fin < 64'(vco_hi_hz)) begin
					alt = (fval > vco + fin) ? fval - vco - fin : vco + fin - fval;
					if (err > alt) begin
						err = alt;
						mult++;
					end
				end
				if (err < best && err <= 64'(tol_hz)) begin
					pcode = 4'(p / 2 - 1);
					best  = err;
					mword = (32'(d - 1) << 18) + (32'(mult - 1) << 8) + (32'(pcode) << 4);
					if (best == 0)
						break;
				end
			end
			if (best == 0)
				break;
		end
		// A winner that packs to zero looks exactly like no match at all.
		if (mword != 0) begin
			mword[24] = 1'b1;
			if (use_xtal)
				mword[3:0] = (clk_in_hz < FastXtalHz) ? CcssSlowXtal : CcssFastXtal;
			else
				mword[3:0] = CcssDirect;
		end
		r.mode_word = mword[24:0];
		r.found     = (mword[24:0] != 0);
		return r;
	endfunction

	// Request driver: one word at a time from the pending queue, with random gaps.
	// No word goes out while register writes are still pending.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid      <= 1'b0;
			req.desired_hz <= '0;
		end else begin
			if (req.valid && req.ready) begin
				mode_q.push_back(search_mode(req.desired_hz));
				words_sent++;
			end
			if (!req.valid || req.ready) begin
				if (desired_q.size() != 0 && !hold_req &&
				    cfg_q.size() == 0 && !cfg.valid &&
				    (quiet_stretch || $urandom_range(99) >= 27)) begin
					req.valid      <= 1'b1;
					req.desired_hz <= desired_q.pop_front();
				end else begin
					req.valid <= 1'b0;
				end
			end
		end
	end

	// Config driver: register writes only go out while the request side is quiet.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg.valid <= 1'b0;
			cfg.index <= '0;
			cfg.data  <= '0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					RegInputClock: clk_in_hz    <= cfg.data;
					RegTolerance:  tol_hz       <= cfg.data;
					RegVcoMax:     vco_hi_hz    <= cfg.data;
					RegVcoMin:     vco_lo_hz    <= cfg.data;
					RegPllInMin:   pll_in_lo_hz <= cfg.data;
					RegCrystal:    use_xtal     <= cfg.data[0];
					default: begin
					end
				endcase
			end
			if (!cfg.valid || cfg.ready) begin
				if (cfg_q.size() != 0) begin
					cfg.valid <= 1'b1;
					{cfg.index, cfg.data} <= cfg_q.pop_front();
				end else begin
					cfg.valid <= 1'b0;
				end
			end
		end
	end

	// Response monitor: ready stalls at random, each accepted word is checked in order.
	always @(posedge clk or negedge arst_n) begin
		mode_rsp_t exp_rsp;
		if (!arst_n) begin
			rsp.ready <= 1'b0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				if (mode_q.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected response word mode_word=%h", rsp.mode_word);
				end else begin
					exp_rsp = mode_q.pop_front();
					words_checked++;
					if (rsp.found)
						words_found++;
					if (rsp.mode_word !== exp_rsp.mode_word || rsp.found !== exp_rsp.found) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: expected mode_word=%h found=%b, got %h %b",
							         exp_rsp.mode_word, exp_rsp.found,
							         rsp.mode_word, rsp.found);
					end
				end
			end
			rsp.ready <= quiet_stretch || ($urandom_range(99) >= 27);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= LimitCycles) begin
			$display("timeout after %0d cycles", cycles);
			$display("TB_ERROR");
			$finish;
		end
	end

	// Waits until every queued word has been sent and answered and every register write has gone out, then settles.
	task automatic wait_idle();
		while (desired_q.size() != 0 || req.valid || mode_q.size() != 0 || cfg_q.size() != 0 ||
		       cfg.valid)
			@(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		cfg_q.push_back({idx, val});
	endtask

	// Frequencies near a useful target so most random words land inside the search.
	function automatic logic [31:0] pick_freq();
		case ($urandom_range(9))
			0:       return $urandom();
			1:       return $urandom_range(1000);
			2:       return 32'hFFFF_FFFF - $urandom_range(3);
			default: return $urandom_range(400000000, 1000000);
		endcase
	endfunction

	task automatic run_words(input int n);
		for (int i = 0; i < n; i++)
			desired_q.push_back(pick_freq());
	endtask

	initial begin
		clk           = 1'b0;
		cycles        = 0;
		mismatches    = 0;
		words_sent    = 0;
		words_checked = 0;
		words_found   = 0;
		quiet_stretch = 1'b0;
		hold_req      = 1'b0;
		clk_in_hz     = 32'd20000000;
		tol_hz        = 32'd500000;
		vco_hi_hz     = 32'd350000000;
		vco_lo_hz     = 32'd100000000;
		pll_in_lo_hz  = 32'd500000;
		use_xtal      = 1'b1;
		arst_n        = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed words at reset settings: field extremes, an exact hit, 10 MHz
		// (D=1, M=1, P=2 would give it, but that VCO is below the minimum) and divide-by-one.
		desired_q.push_back(32'd0);
		desired_q.push_back(32'hFFFF_FFFF);
		desired_q.push_back(32'h5555_5555);
		desired_q.push_back(32'hAAAA_AAAA);
		desired_q.push_back(32'd10000000);
		desired_q.push_back(32'd200000000);
		desired_q.push_back(32'd180000000);
		desired_q.push_back(32'd349999999);
		desired_q.push_back(32'd1);
		desired_q.push_back(32'd33333333);
		wait_idle();

		// Sender holds off with a word queued until hold_req drops again.
		hold_req = 1'b1;
		desired_q.push_back(32'd123456789);
		repeat (50) @(posedge clk);
		hold_req = 1'b0;
		wait_idle();

		// Slow crystal with zero tolerance and zero minimums: an M of zero gets raised.
		write_reg(RegInputClock, 32'd12000000);
		write_reg(RegTolerance, 32'd0);
		write_reg(RegVcoMin, 32'd0);
		write_reg(RegPllInMin, 32'd0);
		desired_q.push_back(32'd96000000);
		desired_q.push_back(32'd100);
		desired_q.push_back(32'd3);
		run_words(10);
		wait_idle();

		// Direct clock input, wide tolerance, and the widest VCO range possible.
		write_reg(RegCrystal, 32'd0);
		write_reg(RegTolerance, 32'hFFFF_FFFE);
		write_reg(RegVcoMax, 32'hFFFF_FFFF);
		write_reg(RegInputClock, 32'hFFFF_FFFF);
		desired_q.push_back(32'hFFFF_FFFF);
		desired_q.push_back(32'd0);
		run_words(12);
		wait_idle();

		// Tiny input clock: the divided input reaches zero and stops the D loop.
		write_reg(RegInputClock, 32'd1);
		write_reg(RegVcoMax, 32'd1);
		write_reg(RegCrystal, 32'd1);
		desired_q.push_back(32'd1);
		desired_q.push_back(32'd2);
		run_words(6);
		wait_idle();

		// Impossible limits: minimums set to the top of the range.
		write_reg(RegInputClock, 32'd25000000);
		write_reg(RegVcoMin, 32'hFFFF_FFFF);
		write_reg(RegPllInMin, 32'hFFFF_FFFF);
		write_reg(RegVcoMax, 32'd350000000);
		run_words(6);
		wait_idle();

		// Back to a realistic fast crystal; a long stretch with no idling first.
		write_reg(RegVcoMin, 32'd100000000);
		write_reg(RegPllInMin, 32'd500000);
		write_reg(RegTolerance, 32'd100000);
		quiet_stretch = 1'b1;
		run_words(20);
		wait_idle();
		quiet_stretch = 1'b0;
		run_words(30);
		wait_idle();

		$display("checked %0d of %0d request words, %0d with a setting found",
		         words_checked, words_sent, words_found);
		$display("covered six register settings including zero, top and tiny-clock limits");
		if (mismatches == 0 && mode_q.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches, %0d words outstanding", mismatches, mode_q.size());
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
